[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mrc_pkg.sv]
// ----------------------------------------------------------------------------
// mrc_pkg
// Types, constants and the CRC-16 byte update of the Modbus RTU reply checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

  localparam int unsigned READ_REGS_DEF = 10;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [7:0]  FN_WRITE_MULTI = 8'h10;
  localparam logic [7:0]  FN_READ_HOLD   = 8'h03;
  localparam logic [8:0]  POS_MAX        = 9'd511;

  // Word counts of a read reply are derived from an 8-bit word index.
  localparam int unsigned FILL_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE_ID = 1'b0,
    CFG_WR_ADDR  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_WR_OK       = 3'd0,
    ST_WR_CRC_ERR  = 3'd1,
    ST_WR_ADDR_ERR = 3'd2,
    ST_WR_ID_ERR   = 3'd3,
    ST_RD_SAME     = 3'd4,
    ST_RD_CHANGED  = 3'd5,
    ST_RD_CRC_ERR  = 3'd6,
    ST_OTHER_FN    = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FINISH
  } back_state_e;

  // One finished frame handed from the front to the back.
  typedef struct packed {
    status_e             status;
    logic                scan;
    logic                bank;
    logic [FILL_W-1:0]   fill;
  } job_t;

  typedef struct packed {
    logic       cur_bank;
    logic [1:0] busy;
  } front_stat_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/mrc_ram.sv]
// ----------------------------------------------------------------------------
// mrc_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/mrc_queue.sv]
// ----------------------------------------------------------------------------
// mrc_queue
// Two-entry job queue between the byte front end and the check back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_queue
  import mrc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t data_i,
  input  wire logic pop_i,
  output job_t      head_o,
  output logic      full_o,
  output logic      empty_o
);

  job_t       entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

  assign head_o  = entry_q[rptr_q];
  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);

endmodule

`default_nettype wire

[rtl/mrc_front.sv]
// ----------------------------------------------------------------------------
// mrc_front
// Byte front end: CRC, header capture, register word capture, frame status.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_front
  import mrc_pkg::*;
#(
  parameter int unsigned READ_REGS = READ_REGS_DEF,
  parameter int unsigned IDX_W     = (READ_REGS > 1) ? $clog2(READ_REGS) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       slave_id_i,
  input  wire logic [15:0]      wr_addr_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic             frame_end_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output job_t                  job_o,
  output logic                  ram_we_o,
  output logic [IDX_W:0]        ram_waddr_o,
  output logic [15:0]           ram_wdata_o,
  input  wire bank_rel_t        rel_i,
  output front_stat_t           stat_o
);

  logic [8:0]        pos_q, pos_d;
  logic [3:0][7:0]   hdr_q, hdr_d;
  logic [15:0]       crc_q, crc_d;
  logic [15:0]       crc_end_q, crc_end_d;
  logic [15:0]       rcrc_q, rcrc_d;
  logic [7:0]        hi_q;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              cur_bank_q;
  logic [1:0]        busy_q, busy_d;

  logic              accept;
  logic [7:0]        fn, bc;
  logic [9:0]        pos10, end_pos;
  logic              is_wr, is_rd;
  logic [8:0]        off;
  logic [7:0]        idx;
  logic              data_wr;
  logic [8:0]        count;
  status_e           status;
  logic              scan;

  assign in_ready_o = !q_full_i && !busy_q[cur_bank_q];
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hdr_d[k] = (pos_q == 9'(k)) ? rx_byte_i : hdr_q[k];
    end
    fn    = hdr_d[1];
    bc    = hdr_d[2];
    pos10 = {1'b0, pos_q};

    is_wr   = (pos_q >= 9'd2) && (fn == FN_WRITE_MULTI);
    is_rd   = !is_wr && (pos_q >= 9'd3) && (fn == FN_READ_HOLD);
    end_pos = is_wr ? 10'd6 : (10'd3 + {2'b00, bc});

    crc_end_d = crc_end_q;
    rcrc_d    = rcrc_q;
    if ((is_wr || is_rd) && (pos10 == end_pos)) begin
      crc_end_d = crc_q;
      rcrc_d    = {rcrc_q[15:8], rx_byte_i};
    end else if ((is_wr || is_rd) && (pos10 == end_pos + 10'd1)) begin
      rcrc_d = {rx_byte_i, rcrc_q[7:0]};
    end

    off     = pos_q - 9'd3;
    idx     = off[8:1];
    data_wr = (fn == FN_READ_HOLD) && (pos_q >= 9'd3) && (pos10 < 10'd3 + {2'b00, bc})
              && (idx < 8'(READ_REGS));
    ram_we_o    = accept && data_wr;
    ram_waddr_o = {cur_bank_q, idx[IDX_W-1:0]};
    ram_wdata_o = off[0] ? {hi_q, rx_byte_i} : {rx_byte_i, 8'h00};
    fill_d      = (data_wr && !off[0]) ? (idx + 8'd1) : fill_q;

    crc_d = crc16_byte(crc_q, rx_byte_i);
    pos_d = (pos_q < POS_MAX) ? (pos_q + 9'd1) : pos_q;
    count = pos_d;

    // A read reply only goes to the register scan when its CRC is good.
    scan = 1'b0;
    if (fn == FN_WRITE_MULTI) begin
      if (hdr_d[0] != slave_id_i) begin
        status = ST_WR_ID_ERR;
      end else if ((hdr_d[2] != wr_addr_i[15:8]) || (hdr_d[3] != wr_addr_i[7:0])) begin
        status = ST_WR_ADDR_ERR;
      end else if ((count < 9'd8) || (rcrc_d != crc_end_d)) begin
        status = ST_WR_CRC_ERR;
      end else begin
        status = ST_WR_OK;
      end
    end else if (fn == FN_READ_HOLD) begin
      if (({1'b0, count} < (10'd5 + {2'b00, bc})) || (rcrc_d != crc_end_d)) begin
        status = ST_RD_CRC_ERR;
      end else begin
        status = ST_RD_SAME;
        scan   = 1'b1;
      end
    end else begin
      status = ST_OTHER_FN;
    end

    push_o       = accept && frame_end_i;
    job_o.status = status;
    job_o.scan   = scan;
    job_o.bank   = cur_bank_q;
    job_o.fill   = fill_d;

    busy_d = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (push_o && scan) begin
      busy_d[cur_bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hdr_q      <= '0;
      crc_q      <= CRC_INIT;
      crc_end_q  <= CRC_INIT;
      rcrc_q     <= '0;
      fill_q     <= '0;
      cur_bank_q <= 1'b0;
      busy_q     <= '0;
    end else begin
      busy_q <= busy_d;
      if (accept) begin
        if (frame_end_i) begin
          pos_q     <= '0;
          hdr_q     <= '0;
          crc_q     <= CRC_INIT;
          crc_end_q <= CRC_INIT;
          rcrc_q    <= '0;
          fill_q    <= '0;
          if (scan) begin
            cur_bank_q <= ~cur_bank_q;
          end
        end else begin
          pos_q     <= pos_d;
          hdr_q     <= hdr_d;
          crc_q     <= crc_d;
          crc_end_q <= crc_end_d;
          rcrc_q    <= rcrc_d;
          fill_q    <= fill_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && data_wr && !off[0]) begin
      hi_q <= rx_byte_i;
    end
  end

  assign stat_o = '{cur_bank: cur_bank_q, busy: busy_q};

endmodule

`default_nettype wire

[rtl/mrc_back.sv]
// ----------------------------------------------------------------------------
// mrc_back
// Check back end: scans received register words against the stored ones and
// drives the registered status output.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_back
  import mrc_pkg::*;
#(
  parameter int unsigned READ_REGS = READ_REGS_DEF,
  parameter int unsigned IDX_W     = (READ_REGS > 1) ? $clog2(READ_REGS) : 1,
  parameter int unsigned CNT_W     = $clog2(READ_REGS + 1)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire job_t        job_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  output bank_rel_t        rel_o,
  output logic [IDX_W:0]   inc_raddr_o,
  input  wire logic [15:0] inc_rdata_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o
);

  back_state_e state_q, state_d;
  logic [CNT_W-1:0] scan_idx_q, scan_idx_d;
  logic             s1_valid_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic             changed_q, changed_d;
  logic             prev_init_q;
  logic             out_valid_q;
  status_e          out_status_q, out_status_d;
  logic             load_out;
  logic             out_free;
  logic             issue;
  logic [15:0]      prev_rdata, inc_eff, prev_eff;

  assign out_free = !out_valid_q || out_ready_i;

  // Stored words start at zero until the first full scan has written them all.
  assign inc_eff  = ({{(FILL_W-IDX_W){1'b0}}, s1_idx_q} < job_i.fill) ? inc_rdata_i : 16'h0000;
  assign prev_eff = prev_init_q ? prev_rdata : 16'h0000;

  mrc_ram #(
    .WIDTH (16),
    .DEPTH (READ_REGS),
    .ADDR_W(IDX_W)
  ) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_idx_q),
    .wdata_i(inc_eff),
    .raddr_i(scan_idx_q[IDX_W-1:0]),
    .rdata_o(prev_rdata)
  );

  assign inc_raddr_o = {job_i.bank, scan_idx_q[IDX_W-1:0]};

  always_comb begin
    state_d      = state_q;
    scan_idx_d   = scan_idx_q;
    changed_d    = changed_q | (s1_valid_q && (inc_eff != prev_eff));
    issue        = 1'b0;
    pop_o        = 1'b0;
    rel_o.valid  = 1'b0;
    rel_o.bank   = job_i.bank;
    load_out     = 1'b0;
    out_status_d = job_i.status;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          if (job_i.scan) begin
            state_d    = BK_SCAN;
            scan_idx_d = '0;
            changed_d  = 1'b0;
          end else if (out_free) begin
            pop_o    = 1'b1;
            load_out = 1'b1;
          end
        end
      end
      BK_SCAN: begin
        issue = (scan_idx_q < CNT_W'(READ_REGS));
        if (issue) begin
          scan_idx_d = scan_idx_q + CNT_W'(1);
        end
        if (s1_valid_q && (s1_idx_q == IDX_W'(READ_REGS - 1))) begin
          state_d = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (out_free) begin
          pop_o        = 1'b1;
          rel_o.valid  = 1'b1;
          load_out     = 1'b1;
          out_status_d = changed_q ? ST_RD_CHANGED : ST_RD_SAME;
          state_d      = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      scan_idx_q  <= '0;
      s1_valid_q  <= 1'b0;
      changed_q   <= 1'b0;
      prev_init_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
      s1_valid_q <= issue;
      changed_q  <= changed_d;
      if (rel_o.valid) begin
        prev_init_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= scan_idx_q[IDX_W-1:0];
    if (load_out) begin
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;

endmodule

`default_nettype wire

[rtl/modbus_rtu_response_checker_unit.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_unit
// Checks Modbus RTU replies (write-multiple and read-holding) byte by byte.
// ----------------------------------------------------------------------------
// Input channel: one received byte per beat (rx_byte_i) with frame_end_i set on
// the last byte of a frame. Output channel: one status beat per frame.
// Configuration: cfg_we_i writes slave ID (index 0) or write start address
// (index 1); write only while no frame is in flight.
// The front end takes one byte per cycle while in_ready_o is high and computes
// the CRC and captures in that cycle. At the frame end it queues a job (two-entry
// queue). A write reply or failed read reply passes from the queue to the registered
// output once the back is idle and the output is free. A good read reply is first
// scanned one register word per cycle against the stored words, then reported.
// Received words sit in a two-bank RAM: the front fills one bank while the back
// scans the other, and the front stalls only when both banks or both queue
// entries are taken. The output status is registered; when the receiver
// stalls the back holds its result and the queue fills before input stalls.
// Reset returns all frame state, configuration and stored words to their
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module modbus_rtu_response_checker_unit
  import mrc_pkg::*;
#(
  parameter int unsigned READ_REGS = READ_REGS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            rx_byte_i,
  input  wire logic                  frame_end_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [2:0]                 status_o
);

  localparam int unsigned IDX_W = (READ_REGS > 1) ? $clog2(READ_REGS) : 1;
  localparam int unsigned CNT_W = $clog2(READ_REGS + 1);

  logic [7:0]  slave_id_q;
  logic [15:0] wr_addr_q;

  logic        q_push, q_pop, q_full, q_empty;
  job_t        job_in, job_head;
  logic        ram_we;
  logic [IDX_W:0] ram_waddr, ram_raddr;
  logic [15:0] ram_wdata, ram_rdata;
  bank_rel_t   bank_rel;
  front_stat_t f_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_id_q <= 8'd17;
      wr_addr_q  <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SLAVE_ID: slave_id_q <= cfg_wdata_i[7:0];
        CFG_WR_ADDR:  wr_addr_q  <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  mrc_front #(
    .READ_REGS(READ_REGS),
    .IDX_W    (IDX_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .slave_id_i (slave_id_q),
    .wr_addr_i  (wr_addr_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .frame_end_i(frame_end_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (job_in),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .rel_i      (bank_rel),
    .stat_o     (f_stat)
  );

  mrc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (job_in),
    .pop_i  (q_pop),
    .head_o (job_head),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  mrc_ram #(
    .WIDTH (16),
    .DEPTH (2 << IDX_W),
    .ADDR_W(IDX_W + 1)
  ) u_inc_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  mrc_back #(
    .READ_REGS(READ_REGS),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job_head),
    .empty_i    (q_empty),
    .pop_o      (q_pop),
    .rel_o      (bank_rel),
    .inc_raddr_o(ram_raddr),
    .inc_rdata_i(ram_rdata),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o)
  );

  `MRC_ASSERT_SAME(a_queue_no_overflow, q_push, !q_full, "job queue overflow")
  `MRC_ASSERT_SAME(a_release_busy_bank, bank_rel.valid, f_stat.busy[bank_rel.bank], "release of idle bank")
  `MRC_ASSERT_SAME(a_fill_free_bank, ram_we, !f_stat.busy[f_stat.cur_bank], "write into busy bank")
  `MRC_ASSERT_NEXT(a_pop_gives_status, q_pop, out_valid_o, "popped job gave no status")

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: Modbus RTU reply checker testbench
// Streams write-acknowledge, read-holding and noise frames into the checker.
// A built-in predictor computes the expected status of every frame, and each
// status beat is compared in order. Register settings change between phases.
// Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrc_pkg::*;

  localparam int NREG        = READ_REGS_DEF;
  localparam int PHASE_BYTES = 235;
  localparam int NUM_PHASES  = 6;
  localparam int WATCHDOG    = 3000;
  localparam int DRAIN       = NREG + 12;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hold;   // pause marker: wait until all statuses are back
  } beat_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            rx_byte_i   = '0;
  logic                  frame_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [2:0]            status_o;

  modbus_rtu_response_checker_unit #(
    .READ_REGS(NREG)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .frame_end_i(frame_end_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state and configuration.
  logic [7:0]  cfg_slave_id;
  logic [15:0] cfg_wr_addr;
  logic [15:0] chk_crc;
  logic [8:0]  chk_pos;
  logic [7:0]  chk_hdr [4];
  logic [15:0] chk_crc_at_end;
  logic [15:0] chk_rx_crc;
  logic [15:0] chk_words  [NREG];
  logic [15:0] chk_stored [NREG];

  beat_t   byte_q[$];
  status_e status_q[$];

  // Frame generator view of the configuration.
  logic [7:0]  gen_id;
  logic [15:0] gen_addr;
  logic [7:0]  last_read[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int err_cnt;
  int bytes_queued;
  int frames_queued;
  int settings_used;
  int idle_cycles;
  int stat_seen [8];

  beat_t   drv_beat;
  status_e drv_status;

  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] crc_over(input logic [7:0] fb[$]);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (fb[i]) begin
      c = crc16_step(c, fb[i]);
    end
    return c;
  endfunction

  function automatic void chk_clear_frame();
    chk_crc        = CRC_INIT;
    chk_pos        = '0;
    chk_crc_at_end = CRC_INIT;
    chk_rx_crc     = '0;
    foreach (chk_hdr[i]) chk_hdr[i] = '0;
    foreach (chk_words[i]) chk_words[i] = '0;
  endfunction

  // Advances the predictor by one received byte; returns 1 when a status is due.
  function automatic bit frame_check_beat(input logic [7:0] b, input logic last,
                                          output status_e st);
    int p;
    int fn;
    int bc;
    int endpos;
    int off;
    int cnt;
    bit changed;
    st = ST_OTHER_FN;
    p  = chk_pos;
    if (p < 4) chk_hdr[p] = b;
    fn = chk_hdr[1];
    bc = chk_hdr[2];

    // Position of the first CRC byte, or -1 while the function is unknown or another code.
    endpos = -1;
    if (p >= 2 && fn == FN_WRITE_MULTI) begin
      endpos = 6;
    end else if (p >= 3 && fn == FN_READ_HOLD) begin
      endpos = 3 + bc;
    end
    if (endpos >= 0 && p == endpos) begin
      chk_crc_at_end  = chk_crc;
      chk_rx_crc[7:0] = b;
    end else if (endpos >= 0 && p == endpos + 1) begin
      chk_rx_crc[15:8] = b;
    end

    if (fn == FN_READ_HOLD && p >= 3 && p < 3 + bc) begin
      off = p - 3;
      if (off / 2 < NREG) begin
        if (off % 2 == 0) begin
          chk_words[off / 2][15:8] = b;
        end else begin
          chk_words[off / 2][7:0] = b;
        end
      end
    end

    chk_crc = crc16_step(chk_crc, b);
    if (chk_pos < POS_MAX) chk_pos = chk_pos + 9'd1;
    if (!last) return 1'b0;

    cnt = chk_pos;
    if (fn == FN_WRITE_MULTI) begin
      if (chk_hdr[0] != cfg_slave_id) begin
        st = ST_WR_ID_ERR;
      end else if ({chk_hdr[2], chk_hdr[3]} != cfg_wr_addr) begin
        st = ST_WR_ADDR_ERR;
      end else if (cnt < 8 || chk_rx_crc != chk_crc_at_end) begin
        st = ST_WR_CRC_ERR;
      end else begin
        st = ST_WR_OK;
      end
    end else if (fn == FN_READ_HOLD) begin
      if (cnt < 5 + bc || chk_rx_crc != chk_crc_at_end) begin
        st = ST_RD_CRC_ERR;
      end else begin
        changed = 1'b0;
        foreach (chk_words[i]) begin
          if (chk_words[i] != chk_stored[i]) changed = 1'b1;
        end
        if (changed) begin
          chk_stored = chk_words;
          st = ST_RD_CHANGED;
        end else begin
          st = ST_RD_SAME;
        end
      end
    end
    chk_clear_frame();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40) $display("%0t MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic queue_frame(input logic [7:0] fb[$]);
    foreach (fb[i]) begin
      byte_q.push_back('{data: fb[i], last: (i == fb.size() - 1), hold: 1'b0});
    end
    bytes_queued += fb.size();
    frames_queued++;
  endtask

  task automatic queue_with_crc(input logic [7:0] fb[$]);
    logic [15:0] c;
    c = crc_over(fb);
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    queue_frame(fb);
  endtask

  task automatic queue_random_frame();
    logic [7:0]  fb[$];
    logic [7:0]  data[$];
    logic [15:0] c;
    int          k;
    int          r;
    int          n;
    int          bc;
    int          idx;
    k = $urandom_range(0, 99);
    if (k >= 82) begin
      // Noise frame, sometimes with a known function code in place.
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) fb.push_back(8'($urandom));
      if (n > 1 && $urandom_range(0, 99) < 35) begin
        fb[1] = $urandom_range(0, 1) ? FN_WRITE_MULTI : FN_READ_HOLD;
      end
      queue_frame(fb);
    end else begin
      if (k < 40) begin
        c = ($urandom_range(0, 99) < 80) ? gen_addr
                                         : gen_addr ^ (16'h1 << $urandom_range(0, 15));
        fb.push_back(($urandom_range(0, 99) < 80) ? gen_id : 8'($urandom));
        fb.push_back(FN_WRITE_MULTI);
        fb.push_back(c[15:8]);
        fb.push_back(c[7:0]);
        fb.push_back(8'($urandom));
        fb.push_back(8'($urandom));
      end else begin
        if (last_read.size() > 0 && $urandom_range(0, 99) < 40) begin
          data = last_read;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 70) begin
            bc = $urandom_range(0, 22);
          end else if (r < 95) begin
            bc = $urandom_range(23, 40);
          end else begin
            bc = $urandom_range(41, 255);
          end
          for (int i = 0; i < bc; i++) data.push_back(8'($urandom));
          last_read = data;
        end
        fb.push_back(8'($urandom));
        fb.push_back(FN_READ_HOLD);
        fb.push_back(8'(data.size()));
        foreach (data[i]) fb.push_back(data[i]);
      end
      c = crc_over(fb);
      fb.push_back(c[7:0]);
      fb.push_back(c[15:8]);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        idx = $urandom_range(0, fb.size() - 1);
        fb[idx] = fb[idx] ^ (8'h1 << $urandom_range(0, 7));
      end else if (r < 22) begin
        n  = $urandom_range(1, fb.size() - 1);
        fb = fb[0:n-1];
      end else if (r < 30) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) fb.push_back(8'($urandom));
      end
      queue_frame(fb);
    end
  endtask

  // Sender: presents queued bytes and predicts each accepted beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      rx_byte_i   <= '0;
      frame_end_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (frame_check_beat(rx_byte_i, frame_end_i, drv_status)) begin
          status_q.push_back(drv_status);
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (byte_q.size() > 0 && byte_q[0].hold && status_q.size() == 0) begin
          void'(byte_q.pop_front());
        end
        if (byte_q.size() > 0 && !byte_q[0].hold &&
            $urandom_range(0, 99) >= tx_idle_pct) begin
          drv_beat     = byte_q.pop_front();
          rx_byte_i   <= drv_beat.data;
          frame_end_i <= drv_beat.last;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i  <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls and in-order status check.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      if (out_valid_o && out_ready_i) begin
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("status %0d with no frame pending", status_o));
        end else begin
          drv_status = status_q.pop_front();
          stat_seen[drv_status]++;
          if (status_o !== drv_status) begin
            report_mismatch($sformatf("status got %0d want %0d (%s)",
                                      status_o, drv_status, drv_status.name()));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG) begin
        $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG);
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0]  fb[$];
    logic [7:0]  new_id;
    logic [15:0] new_addr;
    int          start;
    bit          paused;
    err_cnt       = 0;
    bytes_queued  = 0;
    frames_queued = 0;
    settings_used = 1;
    idle_cycles   = 0;
    foreach (stat_seen[i]) stat_seen[i] = 0;
    cfg_slave_id  = 8'd17;
    cfg_wr_addr   = 16'd1;
    gen_id        = cfg_slave_id;
    gen_addr      = cfg_wr_addr;
    foreach (chk_stored[i]) chk_stored[i] = '0;
    chk_clear_frame();
    tx_idle_pct   = 17;
    rx_idle_pct   = 85;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames at the reset settings.
    fb = '{8'd17, FN_WRITE_MULTI, 8'h00, 8'h01, 8'h00, 8'h0A};
    queue_with_crc(fb);
    fb = '{8'hFF, FN_WRITE_MULTI, 8'h00};       // wrong ID on a short reply
    queue_frame(fb);
    fb = '{8'h00};                              // a lone byte has no function code
    queue_frame(fb);
    fb = '{8'h11, FN_READ_HOLD, 8'h00};         // empty read matches stored zeros
    queue_with_crc(fb);
    fb = '{8'h00, FN_READ_HOLD, 8'h02, 8'hFF, 8'hFF};
    queue_with_crc(fb);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      while (!(byte_q.size() == 0 && !in_valid_i && status_q.size() == 0)) begin
        @(posedge clk_i);
      end
      repeat (DRAIN) @(posedge clk_i);

      case (ph)
        0: begin
          new_id = 8'h00;
          new_addr = 16'h0000;
        end
        1: begin
          new_id = 8'hFF;
          new_addr = 16'hFFFF;
        end
        3: begin
          new_id = 8'd17;
          new_addr = 16'd1;
        end
        default: begin
          new_id = 8'($urandom);
          new_addr = 16'($urandom);
        end
      endcase
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_SLAVE_ID;
      cfg_wdata_i <= {8'h00, new_id};
      @(posedge clk_i);
      cfg_slave_id = new_id;
      cfg_idx_i   <= CFG_WR_ADDR;
      cfg_wdata_i <= new_addr;
      @(posedge clk_i);
      cfg_wr_addr = new_addr;
      cfg_we_i    <= 1'b0;
      gen_id      = new_id;
      gen_addr    = new_addr;
      settings_used++;

      if (ph < 2) begin
        tx_idle_pct = 17;
        rx_idle_pct = 85;
      end else if (ph < 4) begin
        tx_idle_pct = 85;
        rx_idle_pct = 17;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      if (ph == 0) begin
        // Good acknowledge padded well past the saturation of the byte counter.
        fb = '{new_id, FN_WRITE_MULTI, new_addr[15:8], new_addr[7:0], 8'h00, 8'h7B};
        new_addr = crc_over(fb);
        fb.push_back(new_addr[7:0]);
        fb.push_back(new_addr[15:8]);
        for (int i = 0; i < 520; i++) fb.push_back(8'($urandom));
        queue_frame(fb);
      end

      start  = bytes_queued;
      paused = 1'b0;
      while (bytes_queued - start < PHASE_BYTES) begin
        queue_random_frame();
        if (!paused && bytes_queued - start >= PHASE_BYTES / 2) begin
          byte_q.push_back('{data: 8'h00, last: 1'b0, hold: 1'b1});
          paused = 1'b1;
        end
      end
    end

    while (!(byte_q.size() == 0 && !in_valid_i && status_q.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (DRAIN) @(posedge clk_i);

    if (status_q.size() != 0) begin
      report_mismatch($sformatf("%0d statuses never arrived", status_q.size()));
    end
    $display("Sent %0d bytes in %0d frames under %0d register settings.",
             bytes_queued, frames_queued, settings_used);
    $display("Statuses: wr ok %0d, wr crc %0d, wr addr %0d, wr id %0d, rd same %0d, %s",
             stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3], stat_seen[4],
             $sformatf("rd changed %0d, rd crc %0d, other fn %0d",
                       stat_seen[5], stat_seen[6], stat_seen[7]));
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[modbus_rtu_response_checker_unit.f]
+incdir+rtl
rtl/mrc_pkg.sv
rtl/mrc_ram.sv
rtl/mrc_queue.sv
rtl/mrc_front.sv
rtl/mrc_back.sv
rtl/modbus_rtu_response_checker_unit.sv
dv/tb.sv
